// File: hw/rtl/pvng_pkg.sv
// Package for the per-voice noise gate: field widths, request/result/config
// types, register codes and small helper functions. No dependencies.
package pvng_pkg;

  localparam int VOICES_DEF = 8;

  localparam int VOICE_W = 3;
  localparam int SMP_W   = 16;
  localparam int COEF_W  = 25;
  localparam int HOLD_W  = 16;
  localparam int LVL_W   = 15;
  localparam int ENV_W   = 24;
  localparam int GAIN_W  = 25;

  localparam logic [COEF_W-1:0] ONE_Q24 = 25'h100_0000;

  localparam logic [COEF_W-1:0] ENV_COEF_RST     = 25'd173866;
  localparam logic [COEF_W-1:0] ATTACK_COEF_RST  = 25'd1658643;
  localparam logic [COEF_W-1:0] RELEASE_COEF_RST = 25'd13975;
  localparam logic [HOLD_W-1:0] HOLD_SAMPLES_RST = 16'd480;
  localparam logic [LVL_W-1:0]  OPEN_LEVEL_RST   = 15'd655;
  localparam logic [LVL_W-1:0]  CLOSE_LEVEL_RST  = 15'd492;

  typedef enum logic [2:0] {
    REG_ENV_COEF     = 3'd0,
    REG_ATTACK_COEF  = 3'd1,
    REG_RELEASE_COEF = 3'd2,
    REG_HOLD_SAMPLES = 3'd3,
    REG_OPEN_LEVEL   = 3'd4,
    REG_CLOSE_LEVEL  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [VOICE_W-1:0]      voice;
    logic signed [SMP_W-1:0] sample;
    logic                    voice_active;
    logic                    note_start;
    logic                    key_held;
    logic                    frame_last;
  } gate_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] gated_sample;
    logic [GAIN_W-1:0]       gate_gain;
    logic                    frame_last_out;
  } gate_res_t;

  typedef struct packed {
    logic [COEF_W-1:0] env_coef;
    logic [COEF_W-1:0] attack_coef;
    logic [COEF_W-1:0] release_coef;
    logic [HOLD_W-1:0] hold_samples;
    logic [LVL_W-1:0]  open_level;
    logic [LVL_W-1:0]  close_level;
  } gate_cfg_t;

  function automatic logic [COEF_W-1:0] clip_coef(input logic [COEF_W-1:0] c);
    return (c > ONE_Q24) ? ONE_Q24 : c;
  endfunction

  function automatic logic [HOLD_W-1:0] eff_hold(input logic [HOLD_W-1:0] h);
    return (h == '0) ? HOLD_W'(1) : h;
  endfunction

endpackage

// File: hw/rtl/pvng_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pvng_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pvng_regs.sv
// APB-style configuration registers of the noise gate.
// Depends on pvng_pkg.
module pvng_regs import pvng_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output gate_cfg_t   cfg
);

  reg_idx_t idx;

  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.env_coef     <= ENV_COEF_RST;
      cfg.attack_coef  <= ATTACK_COEF_RST;
      cfg.release_coef <= RELEASE_COEF_RST;
      cfg.hold_samples <= HOLD_SAMPLES_RST;
      cfg.open_level   <= OPEN_LEVEL_RST;
      cfg.close_level  <= CLOSE_LEVEL_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ENV_COEF:     cfg.env_coef     <= pwdata[COEF_W-1:0];
        REG_ATTACK_COEF:  cfg.attack_coef  <= pwdata[COEF_W-1:0];
        REG_RELEASE_COEF: cfg.release_coef <= pwdata[COEF_W-1:0];
        REG_HOLD_SAMPLES: cfg.hold_samples <= pwdata[HOLD_W-1:0];
        REG_OPEN_LEVEL:   cfg.open_level   <= pwdata[LVL_W-1:0];
        REG_CLOSE_LEVEL:  cfg.close_level  <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ENV_COEF:     prdata = 32'(cfg.env_coef);
      REG_ATTACK_COEF:  prdata = 32'(cfg.attack_coef);
      REG_RELEASE_COEF: prdata = 32'(cfg.release_coef);
      REG_HOLD_SAMPLES: prdata = 32'(cfg.hold_samples);
      REG_OPEN_LEVEL:   prdata = 32'(cfg.open_level);
      REG_CLOSE_LEVEL:  prdata = 32'(cfg.close_level);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/pvng_core.sv
// Noise gate sequencer: per-voice state RAM, read-modify-write of envelope,
// gain and hold count, output scaling. Depends on pvng_pkg and pvng_ram.
module pvng_core import pvng_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  gate_cfg_t cfg,
  input  logic      sample_valid,
  output logic      sample_stall,
  input  gate_req_t sample_req,
  output logic      result_valid,
  input  logic      result_stall,
  output gate_res_t result
);

  localparam int AW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int MEM_W = ENV_W + GAIN_W + HOLD_W;
  localparam int PW    = 52;
  localparam int AWIDE = 53;
  localparam logic signed [AWIDE-1:0] HALF = AWIDE'(64'd8388608);

  typedef enum logic [2:0] {
    S_IDLE, S_ENV, S_HOLD, S_GAIN, S_MIX, S_PROD, S_OUT
  } state_t;

  state_t                 state;
  gate_req_t              req;
  logic [AW-1:0]          addr;
  logic                   in_range;
  logic [VOICES-1:0]      vld;
  logic [ENV_W-1:0]       env_base;
  logic [GAIN_W-1:0]      gain_base;
  logic [HOLD_W-1:0]      hold;
  logic signed [PW-1:0]   prod;
  logic                   res_valid;
  gate_res_t              res;

  logic [6:0]             voice_ext;
  logic                   ram_we;
  logic [MEM_W-1:0]       ram_wdata;
  logic [MEM_W-1:0]       ram_rdata;

  logic [ENV_W-1:0]       env_b;
  logic [GAIN_W-1:0]      gain_b;
  logic [HOLD_W-1:0]      hold_b;
  logic [HOLD_W-1:0]      hold1;
  logic signed [16:0]     s17;
  logic signed [16:0]     abs17;
  logic [ENV_W-1:0]       mag;
  logic signed [25:0]     diff_e;
  logic signed [25:0]     diff_g;
  logic signed [25:0]     coef_s;
  logic signed [AWIDE-1:0] acc_e;
  logic signed [AWIDE-1:0] acc_g;
  logic signed [AWIDE-1:0] acc_o;
  logic [ENV_W-1:0]       env_new;
  logic [HOLD_W-1:0]      hold2;
  logic [GAIN_W-1:0]      target;
  logic [GAIN_W-1:0]      gain_new;
  logic [GAIN_W-1:0]      gain_out;
  logic signed [28:0]     q;
  logic signed [SMP_W-1:0] q_sat;
  logic [HOLD_W-1:0]      hold_eff;

  assign voice_ext    = {4'b0, sample_req.voice};
  assign sample_stall = (state != S_IDLE);
  assign result_valid = res_valid;
  assign result       = res;
  assign hold_eff     = eff_hold(cfg.hold_samples);

  pvng_ram #(.WIDTH(MEM_W), .DEPTH(VOICES)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (voice_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Envelope stage: select base state, key reload, follower product.
  always_comb begin
    if (req.note_start && in_range) begin
      env_b  = '0;
      gain_b = ONE_Q24;
      hold_b = hold_eff;
    end else if (!vld[addr]) begin
      env_b  = '0;
      gain_b = ONE_Q24;
      hold_b = '0;
    end else begin
      env_b  = ram_rdata[MEM_W-1 -: ENV_W];
      gain_b = ram_rdata[HOLD_W +: GAIN_W];
      hold_b = ram_rdata[HOLD_W-1:0];
    end
    hold1  = req.key_held ? hold_eff : hold_b;
    s17    = {req.sample[SMP_W-1], req.sample};
    abs17  = s17[16] ? -s17 : s17;
    mag    = {abs17[15:0], 8'b0};
    diff_e = $signed({2'b0, mag}) - $signed({2'b0, env_b});
  end

  // Hold stage: finish follower, apply thresholds.
  always_comb begin
    acc_e   = $signed({5'b0, env_base, 24'b0}) + $signed({prod[PW-1], prod}) + HALF;
    env_new = acc_e[47:24];
    if (env_new >= {1'b0, cfg.open_level, 8'b0}) begin
      hold2 = hold_eff;
    end else if (env_new <= {1'b0, cfg.close_level, 8'b0} && hold != '0) begin
      hold2 = hold - HOLD_W'(1);
    end else begin
      hold2 = hold;
    end
  end

  // Gain stage: glide toward one or zero; state RAM write enable and data.
  always_comb begin
    target = (hold != '0) ? ONE_Q24 : '0;
    diff_g = $signed({1'b0, target}) - $signed({1'b0, gain_base});
    case (state)
      S_ENV:   coef_s = $signed({1'b0, clip_coef(cfg.env_coef)});
      default: coef_s = (hold != '0) ? $signed({1'b0, clip_coef(cfg.attack_coef)})
                                     : $signed({1'b0, clip_coef(cfg.release_coef)});
    endcase
    acc_g    = $signed({4'b0, gain_base, 24'b0}) + $signed({prod[PW-1], prod}) + HALF;
    gain_new = acc_g[48:24];
    gain_out = (in_range && req.voice_active) ? gain_new : ONE_Q24;
    ram_we   = (state == S_MIX) && in_range && (req.voice_active || req.note_start);
    ram_wdata = req.voice_active ? {env_base, gain_new, hold}
                                 : {{ENV_W{1'b0}}, ONE_Q24, hold_eff};
  end

  // Output rounding and saturation.
  always_comb begin
    acc_o = $signed({prod[PW-1], prod}) + HALF;
    q     = acc_o[AWIDE-1:24];
    if (q > 29'sd32767) begin
      q_sat = 16'sh7FFF;
    end else if (q < -29'sd32768) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = q[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && !result_stall && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            req      <= sample_req;
            addr     <= voice_ext[AW-1:0];
            in_range <= (voice_ext < 7'(VOICES));
            state    <= S_ENV;
          end
        end
        S_ENV: begin
          env_base  <= env_b;
          gain_base <= gain_b;
          hold      <= hold1;
          prod      <= PW'(diff_e * coef_s);
          state     <= S_HOLD;
        end
        S_HOLD: begin
          env_base <= env_new;
          hold     <= hold2;
          state    <= S_GAIN;
        end
        S_GAIN: begin
          prod  <= PW'(diff_g * coef_s);
          state <= S_MIX;
        end
        S_MIX: begin
          if (ram_we) begin
            vld[addr] <= 1'b1;
          end
          gain_base <= gain_out;
          state     <= S_PROD;
        end
        S_PROD: begin
          prod  <= PW'(req.sample * $signed({1'b0, gain_base}));
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || !result_stall) begin
            res.gated_sample   <= q_sat;
            res.gate_gain      <= gain_base;
            res.frame_last_out <= req.frame_last;
            res_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/per_voice_noise_gate_top.sv
// Per-voice noise gate with hysteresis and hold: top level.
// Requests step through S_ENV, S_HOLD, S_GAIN, S_MIX, S_PROD, S_OUT; a new request
// is taken only back in S_IDLE, after the voice state RAM read-modify-write.
// A stalled result holds the sequencer in its last step only.
// Reset (rst, synchronous): registers to defaults, every voice reads as
// envelope 0, gain one, hold 0 through per-voice valid bits; no clearing pass.
module per_voice_noise_gate_top import pvng_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  gate_req_t   sample_req,
  output logic        result_valid,
  input  logic        result_stall,
  output gate_res_t   result
);

  gate_cfg_t cfg;

  assign pready = 1'b1;

  pvng_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  pvng_core #(.VOICES(VOICES)) u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_req   (sample_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("request accepted while sequencer not busy afterwards");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result appeared without a request in progress");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.gate_gain <= ONE_Q24))
    else $error("gate gain above one");

endmodule
